// File: rtl/bcu_pkg.sv
// shared constants, types and microcode table of the binomial coefficient unit
package bcu_pkg;

    localparam int MAX_N   = 62;
    localparam int N_W     = 7;
    localparam int COEF_W  = 63;
    localparam int STAT_W  = 2;
    localparam int ACC_W   = 64;
    localparam int FAC_W   = 6;
    localparam int IDX_W   = 6;
    localparam int M_W     = 5;
    localparam int REM_W   = 5;
    localparam int DCNT_W  = $clog2(ACC_W);

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL,
        OP_DIV,
        OP_NEXT,
        OP_PUSH
    } t_uop;

    typedef enum logic [2:0] {
        CND_NEVER,
        CND_ALWAYS,
        CND_NO_IN,
        CND_DONE,
        CND_DIV_MORE,
        CND_OUT_BUSY
    } t_cond;

    typedef logic [2:0] t_uaddr;

    localparam t_uaddr UA_WAIT  = 3'd0;
    localparam t_uaddr UA_CHECK = 3'd1;
    localparam t_uaddr UA_MUL   = 3'd2;
    localparam t_uaddr UA_DIV   = 3'd3;
    localparam t_uaddr UA_NEXT  = 3'd4;
    localparam t_uaddr UA_OUT   = 3'd5;
    localparam t_uaddr UA_BACK  = 3'd6;

    typedef struct packed {
        t_uop   op;
        t_cond  cond;
        t_uaddr target;
    } t_uword;

    // jump to target when cond holds, else fall through to the next step
    function automatic t_uword ucode_rom(input t_uaddr addr);
        t_uword w;
        case (addr)
            UA_WAIT:  w = '{op: OP_LOAD, cond: CND_NO_IN,    target: UA_WAIT};
            UA_CHECK: w = '{op: OP_NOP,  cond: CND_DONE,     target: UA_OUT};
            UA_MUL:   w = '{op: OP_MUL,  cond: CND_NEVER,    target: UA_WAIT};
            UA_DIV:   w = '{op: OP_DIV,  cond: CND_DIV_MORE, target: UA_DIV};
            UA_NEXT:  w = '{op: OP_NEXT, cond: CND_ALWAYS,   target: UA_CHECK};
            UA_OUT:   w = '{op: OP_PUSH, cond: CND_OUT_BUSY, target: UA_OUT};
            UA_BACK:  w = '{op: OP_NOP,  cond: CND_ALWAYS,   target: UA_WAIT};
            default:  w = '{op: OP_NOP,  cond: CND_ALWAYS,   target: UA_WAIT};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/bcu_if.sv
// valid/ready channel interfaces for operand and result beats
interface bcu_in_if
    import bcu_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [N_W-1:0]   top_count;
    logic signed [N_W-1:0]   pick_count;

    modport source (output valid, output top_count, output pick_count, input ready);
    modport sink   (input valid, input top_count, input pick_count, output ready);
endinterface

interface bcu_out_if
    import bcu_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [COEF_W-1:0]    coefficient;
    logic [STAT_W-1:0]    status;

    modport source (output valid, output coefficient, output status, input ready);
    modport sink   (input valid, input coefficient, input status, output ready);
endinterface

// File: rtl/binomial_coefficient_unit.sv
// binomial coefficient unit: C(n,k) over signed 7-bit operands, microcoded sequencer
//
// i_in carries one beat per request: top_count (n) and pick_count (k), both signed.
// o_out returns one beat per request: coefficient and status (0 ok, 1 k outside
// 0..n, 2 n above 62). k equal to 0 or to n always answers 1 with status ok.
// A small microcode table steps a 64-bit accumulator through m = min(k, n-k)
// rounds of multiply by (n-m+i) and exact divide by i. The divide is bit serial,
// one quotient bit per cycle; each round runs the check, multiply, divide and
// next steps in that order, and trivial and error cases go straight to output.
// One item is worked at a time; i_in.ready is high only while the
// sequencer waits for a beat.
// The result sits in an output register: the next beat is accepted while it
// waits, and the sequencer holds its finished result only if the register is
// still occupied. i_rst_n (synchronous, active low) returns the sequencer to
// its wait step and drops o_out.valid.
module binomial_coefficient_unit
    import bcu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    bcu_in_if.sink     i_in,
    bcu_out_if.source  o_out
);

    t_uaddr              r_upc, n_upc;
    logic [ACC_W-1:0]    r_acc;
    logic [REM_W-1:0]    r_rem;
    logic [DCNT_W-1:0]   r_dcnt;
    logic [IDX_W-1:0]    r_i;
    logic [M_W-1:0]      r_m;
    logic [FAC_W-1:0]    r_base;
    logic [STAT_W-1:0]   r_status;
    logic                r_out_valid;
    logic [COEF_W-1:0]   r_out_coef;
    logic [STAT_W-1:0]   r_out_status;

    t_uword              w_uw;
    logic                w_jump;
    logic                w_in_acc;
    logic                w_out_free;
    logic                w_ld, w_mul, w_div, w_nxt, w_push;

    logic signed [N_W:0] w_n, w_k, w_d, w_m8, w_b8;
    logic                w_trivial, w_bad_k, w_too_big;
    logic [FAC_W-1:0]    w_fac;
    logic [ACC_W+FAC_W-1:0] w_prod;
    logic [REM_W:0]      w_trial;
    logic                w_ge;

    assign w_uw       = ucode_rom(r_upc);
    assign i_in.ready = (w_uw.op == OP_LOAD);
    assign w_in_acc   = i_in.valid & i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    // jump condition and next step
    always_comb begin
        case (w_uw.cond)
            CND_NEVER:    w_jump = 1'b0;
            CND_ALWAYS:   w_jump = 1'b1;
            CND_NO_IN:    w_jump = !w_in_acc;
            CND_DONE:     w_jump = (r_i > {1'b0, r_m});
            CND_DIV_MORE: w_jump = (r_dcnt != {DCNT_W{1'b1}});
            CND_OUT_BUSY: w_jump = !w_out_free;
            default:      w_jump = 1'b1;
        endcase
        n_upc = w_jump ? w_uw.target : t_uaddr'(r_upc + 3'd1);
    end

    // datapath strobes from the control word
    always_comb begin
        w_ld   = 1'b0;
        w_mul  = 1'b0;
        w_div  = 1'b0;
        w_nxt  = 1'b0;
        w_push = 1'b0;
        case (w_uw.op)
            OP_LOAD: w_ld   = w_in_acc;
            OP_MUL:  w_mul  = 1'b1;
            OP_DIV:  w_div  = 1'b1;
            OP_NEXT: w_nxt  = 1'b1;
            OP_PUSH: w_push = w_out_free;
            OP_NOP:  w_ld   = 1'b0;
            default: w_ld   = 1'b0;
        endcase
    end

    // operand classification
    always_comb begin
        w_n       = {i_in.top_count[N_W-1], i_in.top_count};
        w_k       = {i_in.pick_count[N_W-1], i_in.pick_count};
        w_d       = w_n - w_k;
        w_m8      = (w_d < w_k) ? w_d : w_k;
        w_b8      = w_n - w_m8;
        w_trivial = (w_k == '0) || (w_k == w_n);
        w_bad_k   = (w_k < 0) || (w_k > w_n);
        w_too_big = (w_n > $signed((N_W+1)'(MAX_N)));
    end

    assign w_fac   = r_base + r_i;
    assign w_prod  = r_acc * w_fac;
    assign w_trial = {r_rem, r_acc[ACC_W-1]};
    assign w_ge    = (w_trial >= r_i);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= UA_WAIT;
            r_out_valid <= 1'b0;
        end else begin
            r_upc <= n_upc;
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld) begin
            r_i <= IDX_W'(1);
            if (w_trivial) begin
                r_acc    <= ACC_W'(1);
                r_m      <= '0;
                r_status <= ST_OK;
            end else if (w_bad_k) begin
                r_acc    <= '0;
                r_m      <= '0;
                r_status <= ST_RANGE;
            end else if (w_too_big) begin
                r_acc    <= '0;
                r_m      <= '0;
                r_status <= ST_OVERFLOW;
            end else begin
                r_acc    <= ACC_W'(1);
                r_m      <= w_m8[M_W-1:0];
                r_base   <= w_b8[FAC_W-1:0];
                r_status <= ST_OK;
            end
        end
        if (w_mul) begin
            r_acc  <= w_prod[ACC_W-1:0];
            r_rem  <= '0;
            r_dcnt <= '0;
        end
        // restoring divide: quotient bits shift in as dividend bits shift out
        if (w_div) begin
            r_acc  <= {r_acc[ACC_W-2:0], w_ge};
            r_rem  <= w_ge ? REM_W'(w_trial - r_i) : w_trial[REM_W-1:0];
            r_dcnt <= r_dcnt + DCNT_W'(1);
        end
        if (w_nxt) begin
            r_i <= r_i + IDX_W'(1);
        end
        if (w_push) begin
            r_out_coef   <= r_acc[COEF_W-1:0];
            r_out_status <= r_status;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.coefficient = r_out_coef;
    assign o_out.status      = r_out_status;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == UA_DIV) |-> ({1'b0, r_rem} < r_i))
        else $error("divider remainder not below divisor");

    a_round_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == UA_MUL) |-> (r_i <= {1'b0, r_m}) && (r_i != '0))
        else $error("multiply round index out of range");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_OK) |-> (o_out.coefficient == '0))
        else $error("error status with nonzero coefficient");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.status == ST_OK || o_out.status == ST_RANGE ||
                         o_out.status == ST_OVERFLOW))
        else $error("undefined status code");
`endif

endmodule

// File: tb/bcu_result_checker.sv
// result checker for the binomial coefficient unit: predicts every result beat and compares it
`timescale 1ns / 1ps

module bcu_result_checker
    import bcu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    bcu_in_if    i_in,
    bcu_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    typedef struct {
        logic signed [N_W-1:0] top_count;
        logic signed [N_W-1:0] pick_count;
        logic [COEF_W-1:0]     coefficient;
        logic [STAT_W-1:0]     status;
    } t_binomial_expect;

    t_binomial_expect binomial_q[$];

    function automatic t_binomial_expect predict_binomial(
        input logic signed [N_W-1:0] n_in,
        input logic signed [N_W-1:0] k_in
    );
        t_binomial_expect res;
        logic [ACC_W-1:0] acc;
        logic [ACC_W-1:0] factor;
        int nv;
        int kv;
        int m;
        int i;
        nv = n_in;
        kv = k_in;
        res.top_count  = n_in;
        res.pick_count = k_in;
        acc = '0;
        if (kv == 0 || kv == nv) begin
            // trivial case wins over every range check
            acc        = 1;
            res.status = ST_OK;
        end else if (kv < 0 || kv > nv) begin
            res.status = ST_RANGE;
        end else if (nv > MAX_N) begin
            res.status = ST_OVERFLOW;
        end else begin
            m   = (nv - kv < kv) ? nv - kv : kv;
            acc = 1;
            for (i = 1; i <= m; i++) begin
                factor = ACC_W'(nv - m + i);
                acc    = acc * factor / ACC_W'(i);
            end
            res.status = ST_OK;
        end
        res.coefficient = acc[COEF_W-1:0];
        return res;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    always @(posedge i_clk) begin
        t_binomial_expect want;
        if (i_rst_n) begin
            // result side first: a beat accepted now cannot answer itself
            if (i_out.valid && i_out.ready) begin
                o_checked++;
                if (binomial_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected: coefficient %0d status %0d",
                             $time, i_out.coefficient, i_out.status);
                    o_fail_count++;
                end else begin
                    want = binomial_q.pop_front();
                    if (i_out.coefficient !== want.coefficient ||
                        i_out.status !== want.status) begin
                        $display("%0t: C(%0d,%0d) expected coefficient %0d status %0d, got %0d status %0d",
                                 $time, want.top_count, want.pick_count, want.coefficient,
                                 want.status, i_out.coefficient, i_out.status);
                        o_fail_count++;
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                binomial_q.push_back(predict_binomial(i_in.top_count, i_in.pick_count));
            o_pending = binomial_q.size();
        end
    end

endmodule

// File: tb/binomial_coefficient_unit_test.sv
// top of the binomial coefficient unit testbench: clock, reset, operand and result traffic, verdict
`timescale 1ns / 1ps

module binomial_coefficient_unit_test;
    import bcu_pkg::*;

    localparam int RESET_CYCLES = 8;
    localparam int DIRECTED_ITEMS = 24;
    localparam int RANDOM_ITEMS = 250;
    localparam int HOLD_AT_ITEM = 60;
    localparam int HOLD_CYCLES = 6000;
    localparam int DRAIN_CYCLES = 2200;
    localparam int CYCLE_LIMIT = 3000000;

    // corners: trivial answers for any n, widest step counts, range errors, overflow
    localparam int DIR_N [DIRECTED_ITEMS] = '{
        0, -64, -64, 63, 63, -1, 62, 62, 62, 61, 2, 10,
        40, 5, 5, -1, -64, 63, 0, 63, 63, 63, 62, -5
    };
    localparam int DIR_K [DIRECTED_ITEMS] = '{
        0, -64, 0, 63, 0, -1, 31, 1, 61, 30, 1, 3,
        20, -1, 6, 5, 63, -64, 1, 1, 62, 31, 30, 3
    };

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending_count;
    int   checked_count;
    int   items_sent = 0;
    int   cycle_count = 0;

    bcu_in_if  in_if ();
    bcu_out_if out_if ();

    binomial_coefficient_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    bcu_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_if),
        .i_out        (out_if),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_operands(input int nv, input int kv);
        in_if.valid      <= 1'b1;
        in_if.top_count  <= N_W'(nv);
        in_if.pick_count <= N_W'(kv);
        do @(posedge i_clk); while (!in_if.ready);
        items_sent++;
    endtask

    initial begin : stimulus
        int nv;
        int kv;
        int m;
        int burst;
        int gap;
        int it;
        int b;
        int d;
        in_if.valid      <= 1'b0;
        in_if.top_count  <= '0;
        in_if.pick_count <= '0;
        i_rst_n          <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (d = 0; d < DIRECTED_ITEMS; d++)
            send_operands(DIR_N[d], DIR_K[d]);

        it = 0;
        while (it < RANDOM_ITEMS) begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
            for (b = 0; b < burst && it < RANDOM_ITEMS; b++, it++) begin
                case ($urandom_range(0, 19))
                    0, 1, 2: begin
                        nv = int'($urandom_range(0, 127)) - 64;
                        kv = $urandom_range(0, 1) ? 0 : nv;
                    end
                    3, 4, 5: begin
                        // keep drawing until k falls outside 0..n and is not trivial
                        do begin
                            nv = int'($urandom_range(0, 127)) - 64;
                            kv = int'($urandom_range(0, 127)) - 64;
                        end while (kv == 0 || kv == nv || (kv > 0 && kv < nv));
                    end
                    6, 7: begin
                        nv = MAX_N + 1;
                        kv = $urandom_range(1, MAX_N);
                    end
                    8, 9, 10, 11, 12, 13, 14, 15, 16: begin
                        // few steps keep the run short
                        nv = $urandom_range(2, MAX_N);
                        m  = $urandom_range(1, (nv - 1 < 6) ? nv - 1 : 6);
                        kv = $urandom_range(0, 1) ? m : nv - m;
                    end
                    default: begin
                        nv = $urandom_range(2, MAX_N);
                        kv = $urandom_range(1, nv - 1);
                    end
                endcase
                send_operands(nv, kv);
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            if (gap != 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        in_if.valid <= 1'b0;

        // let the checker log the last beat before looking at the backlog
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d operand beats (%0d corner cases, %0d random), %0d result beats checked",
                 items_sent, DIRECTED_ITEMS, RANDOM_ITEMS, checked_count);
        $display("trivial, range error, overflow and multi-step cases, with a %0d-cycle output back-up",
                 HOLD_CYCLES);
        if (pending_count != 0)
            $display("%0t: %0d result beats never arrived", $time, pending_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("PASS binomial_coefficient_unit");
        end else begin
            $display("FAIL binomial_coefficient_unit");
        end
        $finish;
    end

    initial begin : receiver
        int mode;
        int span;
        int j;
        logic [15:0] pattern;
        bit held;
        held = 1'b0;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            mode    = $urandom_range(0, 2);
            span    = $urandom_range(20, 300);
            pattern = 16'($urandom);
            for (j = 0; j < span; j++) begin
                // one long hold-off so the unit fills up and blocks its input
                if (!held && items_sent >= HOLD_AT_ITEM) begin
                    held = 1'b1;
                    out_if.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end
                case (mode)
                    0:       out_if.ready <= 1'b1;
                    1:       out_if.ready <= pattern[j % 16];
                    default: out_if.ready <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles with %0d beats outstanding", cycle_count, pending_count);
        $display("FAIL binomial_coefficient_unit");
        $finish;
    end

endmodule

// File: files.f
rtl/bcu_pkg.sv
rtl/bcu_if.sv
rtl/binomial_coefficient_unit.sv
tb/bcu_result_checker.sv
tb/binomial_coefficient_unit_test.sv
